### sv/two_level_writeback_cache_unit_macros.svh
// Assertion macros for the two-level write-back cache checker.
`ifndef TWO_LEVEL_WRITEBACK_CACHE_UNIT_MACROS_SVH
`define TWO_LEVEL_WRITEBACK_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLWBC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLWBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/tlwbc_pkg.sv
// Package: geometry constants, codes and controller/datapath types of the cache.
package tlwbc_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int L1_LINES    = 256;
  localparam int L2_LINES    = 512;
  localparam int MEM_BYTES   = 65536;

  localparam int ADDR_W    = 16;
  localparam int WORD_W    = 32;
  localparam int COST_W    = 8;
  localparam int ACC_W     = 11;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int BW        = BLOCK_BYTES / 4;
  localparam int WOFF_W    = $clog2(BW);
  localparam int BOFF_W    = $clog2(BLOCK_BYTES);
  localparam int L1_IDX_W  = $clog2(L1_LINES);
  localparam int L2_IDX_W  = $clog2(L2_LINES);
  localparam int L1_TAG_W  = ADDR_W - BOFF_W - L1_IDX_W;
  localparam int L2_TAG_W  = ADDR_W - BOFF_W - L2_IDX_W;
  localparam int BLK_W     = ADDR_W - BOFF_W;
  localparam int MEM_WORDS = MEM_BYTES / 4;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int L1_WORDS  = L1_LINES * BW;
  localparam int L2_WORDS  = L2_LINES * BW;
  localparam int L1_DAW    = L1_IDX_W + WOFF_W;
  localparam int L2_DAW    = L2_IDX_W + WOFF_W;
  localparam int CNT_W     = $clog2(BW + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L1_RD  = 3'd0,
    REG_L1_WR  = 3'd1,
    REG_L2_RD  = 3'd2,
    REG_L2_WR  = 3'd3,
    REG_MEM_RD = 3'd4,
    REG_MEM_WR = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    COST_NONE,
    COST_L1_RD,
    COST_L1_WR,
    COST_L2_RD,
    COST_L2_WR,
    COST_MEM_RD,
    COST_MEM_WR
  } cost_sel_t;

  typedef enum logic [1:0] {
    CP_L2_TO_MEM,
    CP_MEM_TO_L2,
    CP_L1_TO_L2,
    CP_L2_TO_L1
  } copy_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_L1_REQ,
    S_L1_CHECK,
    S_L2_REQ,
    S_L2_CHECK,
    S_L2_WB,
    S_L2_FILL,
    S_L2_XFER,
    S_L1_ACC,
    S_L1_DONE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [L1_TAG_W-1:0] tag;
  } l1_meta_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [L2_TAG_W-1:0] tag;
  } l2_meta_t;

  typedef struct packed {
    logic      clear;
    logic      load;
    logic      l1_capture;
    logic      l2_capture;
    logic      l2_meta_wr;
    logic      l1_access;
    logic      finish;
    logic      copy;
    copy_t     copy_kind;
    logic      victim;
    cost_sel_t cost_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic addr_err;
    logic l1_hit;
    logic l1_victim_dirty;
    logic l2_hit;
    logic l2_victim_dirty;
    logic copy_done;
  } dp_status_t;

endpackage

### sv/tlwbc_req_if.sv
// Request channel: one word read or write.
interface tlwbc_req_if import tlwbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] write_word;

  modport source (output valid, op, address, write_word, input ready);
  modport sink   (input valid, op, address, write_word, output ready);
endinterface

### sv/tlwbc_rsp_if.sv
// Response channel: read word, hit and error flags, cycle costs.
interface tlwbc_rsp_if import tlwbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  read_word;
  logic               l1_hit;
  logic               addr_error;
  logic [ACC_W-1:0]   access_cycles;
  logic [TOTAL_W-1:0] total_cycles;

  modport source (output valid, read_word, l1_hit, addr_error, access_cycles, total_cycles,
                  input ready);
  modport sink   (input valid, read_word, l1_hit, addr_error, access_cycles, total_cycles,
                  output ready);
endinterface

### sv/tlwbc_cfg_if.sv
// Configuration write channel: register index and data.
interface tlwbc_cfg_if import tlwbc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COST_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/tlwbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlwbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/tlwbc_ctrl.sv
// Controller: sequences lookups, block transfers, clearing and the response.
module tlwbc_ctrl import tlwbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  logic       op_wr,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);
  state_t state, state_next;
  logic   victim, victim_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      victim <= 1'b0;
    end else begin
      state  <= state_next;
      victim <= victim_next;
    end
  end

  always_comb begin
    state_next  = state;
    victim_next = victim;
    cmd         = '0;
    cmd.victim  = victim;
    cmd.cost_sel = COST_NONE;
    cmd.copy_kind = CP_L2_TO_MEM;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load    = 1'b1;
          victim_next = 1'b0;
          state_next  = S_L1_REQ;
        end
      end
      S_L1_REQ: begin
        if (status.addr_err) begin
          cmd.finish = 1'b1;
          state_next = S_RESP;
        end else begin
          state_next = S_L1_CHECK;
        end
      end
      S_L1_CHECK: begin
        cmd.l1_capture = 1'b1;
        if (status.l1_hit) begin
          state_next = S_L1_ACC;
        end else begin
          victim_next = status.l1_victim_dirty;
          state_next  = S_L2_REQ;
        end
      end
      S_L2_REQ: begin
        state_next = S_L2_CHECK;
      end
      S_L2_CHECK: begin
        cmd.l2_capture = 1'b1;
        if (status.l2_hit) begin
          state_next = S_L2_XFER;
        end else if (status.l2_victim_dirty) begin
          state_next = S_L2_WB;
        end else begin
          state_next = S_L2_FILL;
        end
      end
      S_L2_WB: begin
        cmd.copy      = 1'b1;
        cmd.copy_kind = CP_L2_TO_MEM;
        if (status.copy_done) begin
          cmd.cost_sel = COST_MEM_WR;
          state_next   = S_L2_FILL;
        end
      end
      S_L2_FILL: begin
        cmd.copy      = 1'b1;
        cmd.copy_kind = CP_MEM_TO_L2;
        if (status.copy_done) begin
          cmd.cost_sel = COST_MEM_RD;
          state_next   = S_L2_XFER;
        end
      end
      S_L2_XFER: begin
        cmd.copy      = 1'b1;
        cmd.copy_kind = victim ? CP_L1_TO_L2 : CP_L2_TO_L1;
        if (status.copy_done) begin
          cmd.l2_meta_wr = 1'b1;
          cmd.cost_sel   = victim ? COST_L2_WR : COST_L2_RD;
          // after the victim goes down, fetch the wanted block
          if (victim) begin
            victim_next = 1'b0;
            state_next  = S_L2_REQ;
          end else begin
            state_next  = S_L1_ACC;
          end
        end
      end
      S_L1_ACC: begin
        cmd.l1_access = 1'b1;
        cmd.cost_sel  = op_wr ? COST_L1_WR : COST_L1_RD;
        state_next    = S_L1_DONE;
      end
      S_L1_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end
endmodule

### sv/tlwbc_dp.sv
// Datapath: cost registers, tag and data memories, block copy engine, results.
module tlwbc_dp import tlwbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic                 op_wr,
  input  logic                 req_op,
  input  logic [ADDR_W-1:0]    req_address,
  input  logic [WORD_W-1:0]    req_write_word,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data,
  output logic [WORD_W-1:0]    read_word,
  output logic                 l1_hit,
  output logic                 addr_error,
  output logic [ACC_W-1:0]     access_cycles,
  output logic [TOTAL_W-1:0]   total_cycles
);
  logic [COST_W-1:0] l1_rd_cost, l1_wr_cost, l2_rd_cost, l2_wr_cost;
  logic [COST_W-1:0] mem_rd_cost, mem_wr_cost;

  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] wdata_q;
  l1_meta_t          l1m_q, l1m_rd, l1m_wd;
  l2_meta_t          l2m_q, l2m_rd, l2m_wd;
  logic              hit_q, l2hit_q;
  logic [CNT_W-1:0]  cnt;
  logic [MEM_AW-1:0] clr;
  logic [ACC_W-1:0]  cost;
  logic [COST_W-1:0] cost_add;

  logic [L1_IDX_W-1:0] line1;
  logic [L1_TAG_W-1:0] tag1;
  logic [ADDR_W-1:0]   base;
  logic [L2_IDX_W-1:0] line2;
  logic [L2_TAG_W-1:0] tag2;
  logic [WOFF_W-1:0]   rd_word, wr_word;
  logic                copy_wr, err;

  logic [WORD_W-1:0] l1_rd, l2_rd, mem_rd;
  logic [WORD_W-1:0] l1_wd, l2_wd, mem_wd;
  logic [L1_DAW-1:0] l1_raddr, l1_waddr;
  logic [MEM_AW-1:0] mem_waddr;
  logic              l1_we, l2_we, mem_we, l1m_we, l2m_we;

  assign op_wr = op_q;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_rd_cost  <= COST_W'(1);
      l1_wr_cost  <= COST_W'(1);
      l2_rd_cost  <= COST_W'(10);
      l2_wr_cost  <= COST_W'(5);
      mem_rd_cost <= COST_W'(100);
      mem_wr_cost <= COST_W'(50);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_L1_RD:  l1_rd_cost  <= cfg_data;
        REG_L1_WR:  l1_wr_cost  <= cfg_data;
        REG_L2_RD:  l2_rd_cost  <= cfg_data;
        REG_L2_WR:  l2_wr_cost  <= cfg_data;
        REG_MEM_RD: mem_rd_cost <= cfg_data;
        REG_MEM_WR: mem_wr_cost <= cfg_data;
        default: ;
      endcase
    end
  end

  // address fields
  always_comb begin
    line1   = addr_q[BOFF_W +: L1_IDX_W];
    tag1    = addr_q[ADDR_W-1 -: L1_TAG_W];
    base    = cmd.victim ? {l1m_q.tag, line1, BOFF_W'(0)}
                         : {addr_q[ADDR_W-1:BOFF_W], BOFF_W'(0)};
    line2   = base[BOFF_W +: L2_IDX_W];
    tag2    = base[ADDR_W-1 -: L2_TAG_W];
    rd_word = cnt[WOFF_W-1:0];
    wr_word = WOFF_W'(cnt - CNT_W'(1));
    copy_wr = cmd.copy && (cnt != '0);
    err     = (32'(addr_q) >> 2) >= 32'(MEM_WORDS);
  end

  always_comb begin
    unique case (cmd.cost_sel)
      COST_L1_RD:  cost_add = l1_rd_cost;
      COST_L1_WR:  cost_add = l1_wr_cost;
      COST_L2_RD:  cost_add = l2_rd_cost;
      COST_L2_WR:  cost_add = l2_wr_cost;
      COST_MEM_RD: cost_add = mem_rd_cost;
      COST_MEM_WR: cost_add = mem_wr_cost;
      default:     cost_add = '0;
    endcase
  end

  // metadata memories
  always_comb begin
    l1m_we       = cmd.clear || cmd.l1_access;
    l1m_wd.valid = !cmd.clear;
    l1m_wd.dirty = !cmd.clear && (op_q || (hit_q && l1m_q.dirty));
    l1m_wd.tag   = cmd.clear ? '0 : tag1;
    l2m_we       = cmd.clear || cmd.l2_meta_wr;
    l2m_wd.valid = !cmd.clear;
    l2m_wd.dirty = !cmd.clear && (cmd.victim || (l2hit_q && l2m_q.dirty));
    l2m_wd.tag   = cmd.clear ? '0 : tag2;
  end

  tlwbc_ram #(.WIDTH($bits(l1_meta_t)), .DEPTH(L1_LINES)) u_l1_meta (
    .clk   (clk),
    .we    (l1m_we),
    .waddr (cmd.clear ? clr[L1_IDX_W-1:0] : line1),
    .wdata (l1m_wd),
    .raddr (line1),
    .rdata (l1m_rd)
  );

  tlwbc_ram #(.WIDTH($bits(l2_meta_t)), .DEPTH(L2_LINES)) u_l2_meta (
    .clk   (clk),
    .we    (l2m_we),
    .waddr (cmd.clear ? clr[L2_IDX_W-1:0] : line2),
    .wdata (l2m_wd),
    .raddr (line2),
    .rdata (l2m_rd)
  );

  // data memories and the copy engine: read word k, write word k-1
  always_comb begin
    l1_raddr = cmd.copy ? {line1, rd_word} : addr_q[2 +: L1_DAW];
    l1_waddr = cmd.copy ? {line1, wr_word} : addr_q[2 +: L1_DAW];
    l1_we    = (copy_wr && cmd.copy_kind == CP_L2_TO_L1) || (cmd.l1_access && op_q);
    l1_wd    = cmd.copy ? l2_rd : wdata_q;
    l2_we    = copy_wr && (cmd.copy_kind == CP_MEM_TO_L2 || cmd.copy_kind == CP_L1_TO_L2);
    l2_wd    = (cmd.copy_kind == CP_MEM_TO_L2) ? mem_rd : l1_rd;
    mem_we   = cmd.clear || (copy_wr && cmd.copy_kind == CP_L2_TO_MEM);
    mem_wd   = cmd.clear ? '0 : l2_rd;
    mem_waddr = cmd.clear ? clr : MEM_AW'({l2m_q.tag, line2, wr_word});
  end

  tlwbc_ram #(.WIDTH(WORD_W), .DEPTH(L1_WORDS)) u_l1_data (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wd),
    .raddr (l1_raddr),
    .rdata (l1_rd)
  );

  tlwbc_ram #(.WIDTH(WORD_W), .DEPTH(L2_WORDS)) u_l2_data (
    .clk   (clk),
    .we    (l2_we),
    .waddr ({line2, wr_word}),
    .wdata (l2_wd),
    .raddr ({line2, rd_word}),
    .rdata (l2_rd)
  );

  tlwbc_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_backing (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wd),
    .raddr (MEM_AW'({base[ADDR_W-1:BOFF_W], rd_word})),
    .rdata (mem_rd)
  );

  always_comb begin
    status.clear_done      = (clr == MEM_AW'(MEM_WORDS - 1));
    status.addr_err        = err;
    status.l1_hit          = l1m_rd.valid && (l1m_rd.tag == tag1);
    status.l1_victim_dirty = l1m_rd.valid && l1m_rd.dirty;
    status.l2_hit          = l2m_rd.valid && (l2m_rd.tag == tag2);
    status.l2_victim_dirty = l2m_rd.valid && l2m_rd.dirty;
    status.copy_done       = cmd.copy && (cnt == CNT_W'(BW));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      clr   <= '0;
      cost  <= '0;
      total_cycles <= '0;
    end else begin
      if (cmd.copy) begin
        cnt <= (cnt == CNT_W'(BW)) ? '0 : cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (cmd.clear) begin
        clr <= clr + MEM_AW'(1);
      end
      if (cmd.load) begin
        cost <= '0;
      end else begin
        cost <= cost + ACC_W'(cost_add);
      end
      if (cmd.finish && !err) begin
        total_cycles <= total_cycles + TOTAL_W'(cost);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= req_op;
      addr_q  <= req_address;
      wdata_q <= req_write_word;
    end
    if (cmd.l1_capture) begin
      l1m_q <= l1m_rd;
      hit_q <= status.l1_hit;
    end
    if (cmd.l2_capture) begin
      l2m_q   <= l2m_rd;
      l2hit_q <= status.l2_hit;
    end
    if (cmd.finish) begin
      read_word     <= (err || op_q) ? '0 : l1_rd;
      l1_hit        <= !err && hit_q;
      addr_error    <= err;
      access_cycles <= err ? '0 : cost;
    end
  end
endmodule

### sv/two_level_writeback_cache_unit.sv
// Top level: two-level direct-mapped write-back cache over a cleared backing memory.
//
//   channel | dir | payload
//   --------+-----+---------------------------------------------------------
//   req     | in  | op, address, write_word
//   rsp     | out | read_word, l1_hit, addr_error, access_cycles, total_cycles
//   cfg     | in  | index, data (cost registers 0..5)
//
// One access at a time. An L1 hit runs L1_REQ, L1_CHECK, L1_ACC and L1_DONE, then RESP.
// Each block move between levels runs through the single copy engine (one memory
// read and one write per cycle); a worst-case double miss with dirty victims at
// both levels moves six blocks.
// After reset, a clearing pass zeroes backing memory and tags;
// req is held off meanwhile, cfg writes are taken at all times.
// A response stalled on rsp.ready holds the block; no request is taken until it goes.
module two_level_writeback_cache_unit import tlwbc_pkg::*; (
  input logic      clk,
  input logic      rst,
  tlwbc_req_if.sink   req,
  tlwbc_rsp_if.source rsp,
  tlwbc_cfg_if.sink   cfg
);
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       op_wr;

  assign cfg.ready = 1'b1;

  tlwbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .op_wr     (op_wr),
    .status    (status),
    .cmd       (cmd)
  );

  tlwbc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .op_wr          (op_wr),
    .req_op         (req.op),
    .req_address    (req.address),
    .req_write_word (req.write_word),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .read_word      (rsp.read_word),
    .l1_hit         (rsp.l1_hit),
    .addr_error     (rsp.addr_error),
    .access_cycles  (rsp.access_cycles),
    .total_cycles   (rsp.total_cycles)
  );
endmodule

### sv/tlwbc_checker.sv
// Port-level checker for the cache top level, with its bind statement.
`include "two_level_writeback_cache_unit_macros.svh"

module tlwbc_checker import tlwbc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [WORD_W-1:0] rsp_read_word,
  input logic              rsp_l1_hit,
  input logic              rsp_addr_error,
  input logic [ACC_W-1:0]  rsp_access_cycles
);
  `TLWBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `TLWBC_ASSERT_SAME(a_one_at_a_time, rsp_valid, !req_ready, "request taken with a response pending")
  `TLWBC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "second request right after a transfer")
  `TLWBC_ASSERT_SAME(a_err_clean, rsp_valid && rsp_addr_error, (rsp_access_cycles == '0) && !rsp_l1_hit && (rsp_read_word == '0), "error response carries access data")
endmodule

bind two_level_writeback_cache_unit tlwbc_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_read_word     (rsp.read_word),
  .rsp_l1_hit        (rsp.l1_hit),
  .rsp_addr_error    (rsp.addr_error),
  .rsp_access_cycles (rsp.access_cycles)
);
